### rtl/trfh_pkg.sv
// Package for the trace record FNV-1a hasher: shared types and constants.
// Used by trfh_ser, trfh_mix and the top level; depends on nothing.
package trfh_pkg;

  localparam int unsigned HashW = 64;

  // FNV-1a 64 offset basis and prime. The prime is 2^40 + 0x1B3.
  localparam logic [HashW-1:0] FnvBasis    = 64'hCBF2_9CE4_8422_2325;
  localparam int unsigned      FnvPrimeSh  = 40;
  localparam logic [8:0]       FnvPrimeLo  = 9'h1B3;

  // Largest error text length that is accepted; longer lengths saturate.
  localparam logic [15:0]      MaxErrorBytes = 16'hFFFF;

  // Input command codes.
  localparam logic CmdHeader    = 1'b0;
  localparam logic CmdErrorByte = 1'b1;

  // One request to the shared mixing unit.
  typedef struct packed {
    logic       step;
    logic [7:0] data;
  } mix_req_t;

  // Record fields captured by the serializer when a transaction starts.
  typedef struct packed {
    logic [7:0]  action;
    logic [63:0] record_time;
    logic [6:0]  present_mask;
    logic [63:0] event_ident;
    logic [63:0] cause_ident;
    logic [63:0] event_time;
    logic [7:0]  priority_code;
    logic [7:0]  kind_code;
    logic [7:0]  stop_code;
    logic [15:0] error_length;
  } rec_fields_t;

endpackage

### rtl/trfh_mix.sv
// Shared FNV-1a mixing unit: holds the running hash and folds in one byte per cycle
// while a step is requested. Depends on trfh_pkg.
module trfh_mix import trfh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mix_req_t         req_i,
  output logic [HashW-1:0] hash_o
);

  logic [HashW-1:0] hash_q, hash_d;
  logic [HashW-1:0] mixed;

  // Multiplying by 2^40 + 0x1B3 is a shift plus a narrow product, modulo 2^64.
  always_comb begin
    mixed  = hash_q ^ {{(HashW-8){1'b0}}, req_i.data};
    hash_d = hash_q;
    if (req_i.step) begin
      hash_d = (mixed << FnvPrimeSh) + HashW'(mixed * FnvPrimeLo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

endmodule

### rtl/trfh_ser.sv
// Byte serializer: walks the fields of a captured record and feeds the mixing unit
// one byte per cycle. Depends on trfh_pkg.
module trfh_ser import trfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        hdr_i,
  input  rec_fields_t fields_i,
  input  logic [7:0]  byte_i,
  output mix_req_t    req_o,
  output logic        last_o
);

  // Segment numbers: even ones from 2 up are presence bytes, odd ones from 3 up
  // are the optional field contents.
  localparam logic [3:0] SegAction   = 4'd0;
  localparam logic [3:0] SegRecTime  = 4'd1;
  localparam logic [3:0] SegIdent    = 4'd3;
  localparam logic [3:0] SegCause    = 4'd5;
  localparam logic [3:0] SegEvTime   = 4'd7;
  localparam logic [3:0] SegPriority = 4'd9;
  localparam logic [3:0] SegKind     = 4'd11;
  localparam logic [3:0] SegStop     = 4'd13;
  localparam logic [3:0] SegErrLen   = 4'd15;

  logic        active_q, active_d;
  logic        hdr_q, hdr_d;
  logic [3:0]  seg_q, seg_d;
  logic [2:0]  idx_q, idx_d;
  rec_fields_t fld_q, fld_d;

  logic [7:0]  mask_ext;
  logic [63:0] word;
  logic        wide_seg;
  logic        seg_end;
  logic [4:0]  seg_inc;
  logic [4:0]  seg_nxt;
  logic [7:0]  cur_byte;

  // Bit 0 stands for the record time, which is always present.
  assign mask_ext = {fld_q.present_mask, 1'b1};

  always_comb begin
    word     = 64'd0;
    wide_seg = 1'b1;
    case (seg_q)
      SegRecTime: word = fld_q.record_time;
      SegIdent:   word = fld_q.event_ident;
      SegCause:   word = fld_q.cause_ident;
      SegEvTime:  word = fld_q.event_time;
      SegErrLen:  word = {48'd0, fld_q.error_length};
      default:    wide_seg = 1'b0;
    endcase
  end

  always_comb begin
    case (seg_q) inside
      SegAction:   cur_byte = fld_q.action;
      SegRecTime, SegIdent, SegCause, SegEvTime, SegErrLen:
                   cur_byte = word[{idx_q, 3'b000} +: 8];
      SegPriority: cur_byte = fld_q.priority_code;
      SegKind:     cur_byte = fld_q.kind_code;
      SegStop:     cur_byte = fld_q.stop_code;
      default:     cur_byte = {7'd0, mask_ext[seg_q[3:1]]};
    endcase
  end

  // Absent content segments are skipped straight to the next presence byte.
  always_comb begin
    seg_end = !wide_seg || (idx_q == 3'd7);
    seg_inc = {1'b0, seg_q} + 5'd1;
    seg_nxt = seg_inc;
    if (seg_inc[0] && !seg_inc[4] && !mask_ext[seg_inc[3:1]]) begin
      seg_nxt = seg_inc + 5'd1;
    end
    last_o = active_q && seg_end && (!hdr_q || seg_nxt[4]);
  end

  always_comb begin
    active_d = active_q;
    hdr_d    = hdr_q;
    seg_d    = seg_q;
    idx_d    = idx_q;
    fld_d    = fld_q;
    if (start_i) begin
      active_d = 1'b1;
      hdr_d    = hdr_i;
      seg_d    = SegAction;
      idx_d    = 3'd0;
      fld_d    = fields_i;
      if (!hdr_i) begin
        fld_d.action = byte_i;
      end
    end else if (active_q) begin
      if (last_o) begin
        active_d = 1'b0;
      end else if (seg_end) begin
        seg_d = seg_nxt[3:0];
        idx_d = 3'd0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hdr_q    <= 1'b0;
      seg_q    <= SegAction;
      idx_q    <= 3'd0;
    end else begin
      active_q <= active_d;
      hdr_q    <= hdr_d;
      seg_q    <= seg_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fld_q <= fld_d;
  end

  assign req_o.step = active_q;
  assign req_o.data = cur_byte;

endmodule

### rtl/trace_record_fnv1a_hasher.sv
// Top level of the trace record FNV-1a hasher.
// Depends on trfh_pkg, trfh_ser and trfh_mix.
//
// This block keeps a running 64-bit FNV-1a signature over a stream of trace
// records and returns one result transaction for every input transaction. A
// header transaction is serialized into bytes (action, record time, then a
// presence byte and the content of each optional field) and each byte is folded
// into the hash by a single multiply-add unit, one byte per clock cycle. A
// header has 16 bytes at least and 51 at most. An error text transaction
// folds in its one text byte, and an item that is ignored (tracing disabled
// or out of sequence) folds in nothing. The input is not ready while an item
// is being hashed or while its result waits to be handed off. A
// finished result sits in an output register, so the next input transaction is
// taken while the previous result still waits for the consumer. When tracing is
// disabled the result carries a zero hash with hash_valid low and the state is
// untouched. A header that arrives while error text is still pending, or an
// error byte that arrives when none is expected, is ignored and flagged with
// sequence_error. The trace enable register is written through its own channel
// and should only be changed while the block is idle.
module trace_record_fnv1a_hasher import trfh_pkg::*; #(
  parameter logic [15:0] MaxErrBytes = MaxErrorBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_trace_enabled_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  action_i,
  input  logic [63:0] record_time_i,
  input  logic [6:0]  present_mask_i,
  input  logic [63:0] event_ident_i,
  input  logic [63:0] cause_ident_i,
  input  logic [63:0] event_time_i,
  input  logic [7:0]  priority_code_i,
  input  logic [7:0]  kind_code_i,
  input  logic [7:0]  stop_code_i,
  input  logic [15:0] error_length_i,
  input  logic [7:0]  error_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o,
  output logic        hash_valid_o,
  output logic        sequence_error_o
);

  // Sequencer states: waiting for a transaction, hashing bytes, handing off.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        enabled_q, enabled_d;
  logic [15:0] left_q, left_d;
  logic        pend_en_q, pend_en_d;
  logic        pend_seq_q, pend_seq_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hash_q, out_hash_d;
  logic        out_hv_q, out_hv_d;
  logic        out_seq_q, out_seq_d;

  logic        in_fire;
  logic        ser_start;
  logic        ser_last;
  logic        out_load;
  logic [15:0] sat_len;
  logic [63:0] hash;
  mix_req_t    mix_req;
  rec_fields_t fields;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;

  // The error text length saturates at the configured maximum; that value is
  // both hashed and used as the count of text bytes to come.
  assign sat_len = (error_length_i > MaxErrBytes) ? MaxErrBytes : error_length_i;

  always_comb begin
    fields.action        = action_i;
    fields.record_time   = record_time_i;
    fields.present_mask  = present_mask_i;
    fields.event_ident   = event_ident_i;
    fields.cause_ident   = cause_ident_i;
    fields.event_time    = event_time_i;
    fields.priority_code = priority_code_i;
    fields.kind_code     = kind_code_i;
    fields.stop_code     = stop_code_i;
    fields.error_length  = sat_len;
  end

  // The result register is free when empty or when its content leaves now.
  assign out_load = (state_q == StFin) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    enabled_d  = enabled_q;
    left_d     = left_q;
    pend_en_d  = pend_en_q;
    pend_seq_d = pend_seq_q;
    ser_start  = 1'b0;

    if (cfg_valid_i) begin
      enabled_d = cfg_trace_enabled_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          pend_en_d  = enabled_q;
          pend_seq_d = 1'b0;
          state_d    = StFin;
          if (enabled_q) begin
            if (command_i == CmdHeader) begin
              if (left_q != 16'd0) begin
                pend_seq_d = 1'b1;
              end else begin
                ser_start = 1'b1;
                state_d   = StRun;
                if (present_mask_i[6]) begin
                  left_d = sat_len;
                end
              end
            end else begin
              if (left_q == 16'd0) begin
                pend_seq_d = 1'b1;
              end else begin
                ser_start = 1'b1;
                state_d   = StRun;
                left_d    = left_q - 16'd1;
              end
            end
          end
        end
      end
      StRun: begin
        if (ser_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_hash_d  = out_hash_q;
    out_hv_d    = out_hv_q;
    out_seq_d   = out_seq_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_hash_d  = pend_en_q ? hash : 64'd0;
      out_hv_d    = pend_en_q;
      out_seq_d   = pend_seq_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      enabled_q   <= 1'b0;
      left_q      <= 16'd0;
      pend_en_q   <= 1'b0;
      pend_seq_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      enabled_q   <= enabled_d;
      left_q      <= left_d;
      pend_en_q   <= pend_en_d;
      pend_seq_q  <= pend_seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
    out_hv_q   <= out_hv_d;
    out_seq_q  <= out_seq_d;
  end

  trfh_ser u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ser_start),
    .hdr_i    (command_i == CmdHeader),
    .fields_i (fields),
    .byte_i   (error_byte_i),
    .req_o    (mix_req),
    .last_o   (ser_last)
  );

  trfh_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mix_req),
    .hash_o (hash)
  );

  assign out_valid_o      = out_valid_q;
  assign hash_value_o     = out_hash_q;
  assign hash_valid_o     = out_hv_q;
  assign sequence_error_o = out_seq_q;

endmodule

### rtl/trfh_chk.sv
// Port-level checker for the trace record FNV-1a hasher, bound to the top level.
// Depends on trace_record_fnv1a_hasher's port list only.
module trfh_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o,
  input logic        hash_valid_o,
  input logic        sequence_error_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o)
      && $stable(hash_valid_o) && $stable(sequence_error_o))
    else $error("result transaction changed while stalled");

  // With tracing disabled the result carries a zero hash and no sequence error.
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hash_valid_o |-> hash_value_o == 64'd0 && !sequence_error_o)
    else $error("disabled result is not all zero");

  // Input ready drops after every accepted transaction, so no two are taken back to back.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted transaction");

endmodule

bind trace_record_fnv1a_hasher trfh_chk u_trfh_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .hash_value_o     (hash_value_o),
  .hash_valid_o     (hash_valid_o),
  .sequence_error_o (sequence_error_o)
);
